// ----- hdl/oht_pkg.sv -----
// Shared types and constants for the Otsu histogram threshold block.
// No dependencies; used by oht_mul, otsu_histogram_threshold and the bench.
package oht_pkg;

  localparam int GRAY_LEVELS = 256;
  localparam int BIN_W       = 8;
  localparam int CNT_W       = 17;
  localparam int SUM_W       = 25;
  localparam int HIST_W      = 17;
  localparam int WIDTH_W     = 9;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CNT_W-1:0]   COUNT_MAX = 17'h1FFFF;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH = 9'd256;
  localparam logic [BIN_W-1:0]   MAX_ROW   = 8'd255;
  localparam logic [BIN_W-1:0]   EMPTY_THRESHOLD = 8'd255;

  localparam logic [WIDTH_W-1:0] RST_FRAME_WIDTH = 9'd188;
  localparam logic [BIN_W-1:0]   RST_FIRST_ROW   = 8'd40;
  localparam logic [BIN_W-1:0]   RST_MARGIN      = 8'd42;
  localparam logic [BIN_W-1:0]   RST_MIN_THR     = 8'd45;
  localparam logic [BIN_W-1:0]   RST_FALLBACK    = 8'd60;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FRAME_WIDTH = 3'd0,
    CFG_FIRST_ROW   = 3'd1,
    CFG_MARGIN      = 3'd2,
    CFG_MIN_THR     = 3'd3,
    CFG_FALLBACK    = 3'd4
  } cfg_idx_t;

  localparam int MUL_A_W    = 86;
  localparam int MUL_B_W    = 48;
  localparam int MUL_P_W    = 128;
  localparam int DIGIT_W    = 16;
  localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;
  localparam int MUL_K_W    = 2;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

endpackage

// ----- hdl/oht_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module oht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/oht_mul.sv -----
// Digit-serial unsigned multiplier, one 16-bit digit of the b operand per cycle.
// Depends on oht_pkg.
module oht_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  oht_pkg::mul_req_t req,
  output oht_pkg::mul_rsp_t rsp
);

  logic [oht_pkg::MUL_A_W-1:0] a_r;
  logic [oht_pkg::MUL_B_W-1:0] b_r;
  logic [oht_pkg::MUL_P_W-1:0] acc_r;
  logic [oht_pkg::MUL_K_W-1:0] k_r;
  logic                        busy_r;
  logic                        done_r;
  logic [oht_pkg::MUL_P_W-1:0] pp;

  assign pp = oht_pkg::MUL_P_W'(a_r * b_r[oht_pkg::DIGIT_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
        k_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + (pp << (k_r * oht_pkg::DIGIT_W));
        b_r   <= b_r >> oht_pkg::DIGIT_W;
        k_r   <= k_r + 1'b1;
        if (k_r == oht_pkg::MUL_K_W'(oht_pkg::MUL_DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ----- hdl/otsu_histogram_threshold.sv -----
// Otsu threshold over a region of interest; pixels take one cycle each while a frame streams.
// After the last pixel, input stalls through the drain, range scan, threshold search (each bin
// from the lowest occupied one to the one below the highest, paced by the digit-serial
// multiplier and the single RAM read port), clear and hand-off; the result then follows.
// Reset (rst_n low, synchronous) restores the default registers and clears the histogram
// before the first request. Depends on oht_pkg, oht_ram and oht_mul.
module otsu_histogram_threshold (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] pixel
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] threshold
  input  logic                              cfg_we,
  input  logic [oht_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [oht_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  typedef enum logic [3:0] {
    S_ACC, S_DRAIN, S_RANGE, S_OTRD, S_OTWT, S_OTACC, S_MUL, S_CLEAR, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_A, OP_B, OP_W, OP_D, OP_L, OP_R
  } op_t;

  state_t state_r;
  op_t    op_r;

  logic [oht_pkg::WIDTH_W-1:0] fw_r;
  logic [oht_pkg::BIN_W-1:0]   first_row_r, margin_r, min_thr_r, fallback_r;

  logic [oht_pkg::BIN_W-1:0]  col_r, row_r;
  logic [oht_pkg::CNT_W-1:0]  n_r;
  logic [oht_pkg::SUM_W-1:0]  s_r;

  logic                        p1_v_r;
  logic [oht_pkg::BIN_W-1:0]   p1_a_r;
  logic                        lw_v_r;
  logic [oht_pkg::BIN_W-1:0]   lw_a_r;
  logic [oht_pkg::HIST_W-1:0]  lw_d_r;

  logic [8:0]                  cnt_r;
  logic                        rv_r;
  logic [oht_pkg::BIN_W-1:0]   ra_r;
  logic                        found_r;
  logic                        res_v_r;
  logic [oht_pkg::BIN_W-1:0]   lo_r, hi_r, t_r, best_bin_r, res_r;

  logic [oht_pkg::CNT_W-1:0]   bp_r;
  logic [oht_pkg::SUM_W-1:0]   bs_r;
  logic [42:0]                 a_r, d_r;
  logic [33:0]                 w_r, bestw_r;
  logic [85:0]                 dd_r, bestd2_r;
  logic [119:0]                lhs_r;

  logic                        out_valid_r;
  logic [7:0]                  out_data_r;

  logic                        ram_we;
  logic [oht_pkg::BIN_W-1:0]   ram_waddr, ram_raddr;
  logic [oht_pkg::HIST_W-1:0]  ram_wdata, ram_rdata, hist_cur;

  oht_pkg::mul_req_t mreq;
  oht_pkg::mul_rsp_t mrsp;

  logic [oht_pkg::WIDTH_W-1:0] w_eff;
  logic                        in_region, accept;
  logic [42:0]                 b_now;

  assign w_eff = (fw_r == '0) ? oht_pkg::WIDTH_W'(1) :
                 (fw_r > oht_pkg::MAX_WIDTH) ? oht_pkg::MAX_WIDTH : fw_r;
  assign in_region = (row_r >= first_row_r) && (col_r >= margin_r) &&
                     ((9'(col_r) + 9'(margin_r)) < w_eff) && (n_r < oht_pkg::COUNT_MAX);
  assign in_tready = (state_r == S_ACC);
  assign accept    = in_tvalid && in_tready;
  assign b_now     = mrsp.prod[42:0];

  assign hist_cur  = (lw_v_r && lw_a_r == p1_a_r) ? lw_d_r : ram_rdata;
  assign ram_we    = p1_v_r || (state_r == S_CLEAR && !cnt_r[8]);
  assign ram_waddr = p1_v_r ? p1_a_r : cnt_r[7:0];
  assign ram_wdata = p1_v_r ? hist_cur + 1'b1 : '0;
  assign ram_raddr = (state_r == S_ACC)   ? in_tdata :
                     (state_r == S_RANGE) ? cnt_r[7:0] : t_r;

  oht_ram #(.WIDTH(oht_pkg::HIST_W), .DEPTH(oht_pkg::GRAY_LEVELS)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  oht_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= oht_pkg::RST_FRAME_WIDTH;
      first_row_r <= oht_pkg::RST_FIRST_ROW;
      margin_r    <= oht_pkg::RST_MARGIN;
      min_thr_r   <= oht_pkg::RST_MIN_THR;
      fallback_r  <= oht_pkg::RST_FALLBACK;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        oht_pkg::CFG_FRAME_WIDTH: fw_r        <= cfg_wdata;
        oht_pkg::CFG_FIRST_ROW:   first_row_r <= cfg_wdata[7:0];
        oht_pkg::CFG_MARGIN:      margin_r    <= cfg_wdata[7:0];
        oht_pkg::CFG_MIN_THR:     min_thr_r   <= cfg_wdata[7:0];
        oht_pkg::CFG_FALLBACK:    fallback_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lw_a_r <= p1_a_r;
    lw_d_r <= ram_wdata;
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else begin
      lw_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      op_r        <= OP_A;
      col_r       <= '0;
      row_r       <= '0;
      n_r         <= '0;
      s_r         <= '0;
      p1_v_r      <= 1'b0;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      res_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      mreq.start  <= 1'b0;
    end else begin
      p1_v_r     <= 1'b0;
      mreq.start <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_ACC: begin
          if (accept) begin
            p1_a_r <= in_tdata;
            if (in_region) begin
              p1_v_r <= 1'b1;
              n_r    <= n_r + 1'b1;
              s_r    <= s_r + oht_pkg::SUM_W'(in_tdata);
            end
            if (in_tlast) begin
              col_r   <= '0;
              row_r   <= '0;
              res_v_r <= 1'b1;
              state_r <= S_DRAIN;
            end else if ((9'(col_r) + 9'd1) >= w_eff) begin
              col_r <= '0;
              if (row_r < oht_pkg::MAX_ROW) begin
                row_r <= row_r + 1'b1;
              end
            end else begin
              col_r <= col_r + 1'b1;
            end
          end
        end
        S_DRAIN: begin
          cnt_r   <= '0;
          rv_r    <= 1'b0;
          found_r <= 1'b0;
          state_r <= S_RANGE;
        end
        S_RANGE: begin
          rv_r <= !cnt_r[8];
          ra_r <= cnt_r[7:0];
          if (!cnt_r[8]) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (rv_r && ram_rdata != '0) begin
            if (!found_r) begin
              lo_r <= ra_r;
            end
            hi_r    <= ra_r;
            found_r <= 1'b1;
          end
          if (cnt_r[8] && !rv_r) begin
            cnt_r <= '0;
            if (!found_r) begin
              res_r   <= oht_pkg::EMPTY_THRESHOLD;
              state_r <= S_CLEAR;
            end else if (hi_r == lo_r || (lo_r + 1'b1) == hi_r) begin
              res_r   <= lo_r;
              state_r <= S_CLEAR;
            end else begin
              t_r        <= lo_r;
              bp_r       <= '0;
              bs_r       <= '0;
              best_bin_r <= lo_r;
              state_r    <= S_OTRD;
            end
          end
        end
        S_OTRD: begin
          state_r <= S_OTWT;
        end
        S_OTWT: begin
          bp_r    <= bp_r + ram_rdata;
          bs_r    <= bs_r + oht_pkg::SUM_W'(ram_rdata * t_r);
          state_r <= S_OTACC;
        end
        S_OTACC: begin
          mreq.start <= 1'b1;
          mreq.a     <= oht_pkg::MUL_A_W'(bs_r);
          mreq.b     <= oht_pkg::MUL_B_W'(n_r);
          op_r       <= OP_A;
          state_r    <= S_MUL;
        end
        S_MUL: begin
          if (mrsp.done) begin
            unique case (op_r)
              OP_A: begin
                a_r        <= mrsp.prod[42:0];
                mreq.start <= 1'b1;
                mreq.a     <= oht_pkg::MUL_A_W'(s_r);
                mreq.b     <= oht_pkg::MUL_B_W'(bp_r);
                op_r       <= OP_B;
              end
              OP_B: begin
                d_r        <= (a_r > b_now) ? a_r - b_now : b_now - a_r;
                mreq.start <= 1'b1;
                mreq.a     <= oht_pkg::MUL_A_W'(bp_r);
                mreq.b     <= oht_pkg::MUL_B_W'(n_r - bp_r);
                op_r       <= OP_W;
              end
              OP_W: begin
                w_r        <= mrsp.prod[33:0];
                mreq.start <= 1'b1;
                mreq.a     <= oht_pkg::MUL_A_W'(d_r);
                mreq.b     <= oht_pkg::MUL_B_W'(d_r);
                op_r       <= OP_D;
              end
              OP_D: begin
                dd_r <= mrsp.prod[85:0];
                if (t_r == lo_r) begin
                  bestd2_r <= mrsp.prod[85:0];
                  bestw_r  <= w_r;
                  state_r  <= S_OTRD;
                  t_r      <= t_r + 1'b1;
                  if ((t_r + 1'b1) == hi_r) begin
                    res_r   <= (lo_r < min_thr_r) ? fallback_r : lo_r;
                    cnt_r   <= '0;
                    state_r <= S_CLEAR;
                  end
                end else begin
                  mreq.start <= 1'b1;
                  mreq.a     <= mrsp.prod[85:0];
                  mreq.b     <= oht_pkg::MUL_B_W'(bestw_r);
                  op_r       <= OP_L;
                end
              end
              OP_L: begin
                lhs_r      <= mrsp.prod[119:0];
                mreq.start <= 1'b1;
                mreq.a     <= bestd2_r;
                mreq.b     <= oht_pkg::MUL_B_W'(w_r);
                op_r       <= OP_R;
              end
              OP_R: begin
                if (lhs_r > mrsp.prod[119:0]) begin
                  bestd2_r   <= dd_r;
                  bestw_r    <= w_r;
                  best_bin_r <= t_r;
                end
                t_r     <= t_r + 1'b1;
                state_r <= S_OTRD;
                if ((t_r + 1'b1) == hi_r) begin
                  if (lhs_r > mrsp.prod[119:0]) begin
                    res_r <= (t_r < min_thr_r) ? fallback_r : t_r;
                  end else begin
                    res_r <= (best_bin_r < min_thr_r) ? fallback_r : best_bin_r;
                  end
                  cnt_r   <= '0;
                  state_r <= S_CLEAR;
                end
              end
              default: state_r <= S_CLEAR;
            endcase
          end
        end
        S_CLEAR: begin
          if (!cnt_r[8]) begin
            cnt_r <= cnt_r + 1'b1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          n_r   <= '0;
          s_r   <= '0;
          col_r <= '0;
          row_r <= '0;
          if (!res_v_r) begin
            state_r <= S_ACC;
          end else if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            res_v_r     <= 1'b0;
            state_r     <= S_ACC;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> !in_tready)
    else $error("input accepted during threshold search");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && ram_we) |-> (ram_wdata == '0))
    else $error("clear sweep wrote a nonzero bin");

  assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r |-> $past(accept))
    else $error("histogram update without an accepted pixel");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OTWT) |-> (t_r < hi_r))
    else $error("search bin ran past the highest occupied bin");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for otsu_histogram_threshold: streams gray frames, predicts each
// frame's threshold with an in-bench Otsu model and compares every result in order.
// Depends on oht_pkg and the otsu_histogram_threshold RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata = '0;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [7:0]                     out_tdata;
  logic                           cfg_we = 1'b0;
  logic [oht_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [oht_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  otsu_histogram_threshold u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Threshold model state.
  logic [8:0]  cur_width;
  logic [7:0]  cur_first_row, cur_margin, cur_min_thr, cur_fallback;
  int unsigned bin_count[oht_pkg::GRAY_LEVELS];
  int unsigned col_pos, row_pos, roi_pixels, roi_gray_sum;

  logic [7:0] pending_thresholds[$];
  int mismatches = 0;
  int errors = 0;
  int frames_sent = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int burst_left = 0;
  int hold_request = 0;

  function automatic void clear_frame_model();
    foreach (bin_count[i]) bin_count[i] = 0;
    col_pos = 0;
    row_pos = 0;
    roi_pixels = 0;
    roi_gray_sum = 0;
  endfunction

  function automatic logic [7:0] otsu_pick();
    int unsigned lo, hi, best;
    longint unsigned n, s, bp, bs, a, b, d, w, best_d, best_w;
    logic [127:0] lhs, rhs;
    lo = 0;
    while (lo < oht_pkg::GRAY_LEVELS - 1 && bin_count[lo] == 0) lo++;
    hi = oht_pkg::GRAY_LEVELS - 1;
    while (hi > lo && bin_count[hi] == 0) hi--;
    if (hi == lo) return hi[7:0];
    if (lo + 1 == hi) return lo[7:0];
    n = roi_pixels;
    s = roi_gray_sum;
    bp = 0;
    bs = 0;
    best_d = 0;
    best_w = 0;
    best = lo;
    for (int unsigned t = lo; t < hi; t++) begin
      bp += bin_count[t];
      bs += longint'(bin_count[t]) * t;
      a = n * bs;
      b = bp * s;
      d = (a > b) ? a - b : b - a;
      w = bp * (n - bp);
      if (t == lo) begin
        best_d = d;
        best_w = w;
        best = t;
      end else begin
        lhs = 128'(d) * 128'(d) * 128'(best_w);
        rhs = 128'(best_d) * 128'(best_d) * 128'(w);
        if (lhs > rhs) begin
          best_d = d;
          best_w = w;
          best = t;
        end
      end
    end
    if (best < cur_min_thr) best = cur_fallback;
    return best[7:0];
  endfunction

  function automatic void predict_pixel(input logic [7:0] pix, input logic last);
    int unsigned w;
    w = cur_width;
    if (w < 1) w = 1;
    if (w > 256) w = 256;
    if (row_pos >= cur_first_row && col_pos >= cur_margin && col_pos + cur_margin < w &&
        roi_pixels < oht_pkg::COUNT_MAX) begin
      bin_count[pix]++;
      roi_pixels++;
      roi_gray_sum += pix;
    end
    if (last) begin
      pending_thresholds.push_back(otsu_pick());
      clear_frame_model();
    end else if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos < 255) row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  // Result checker and receiver stall pattern.
  int hold_left = 0;
  int rx_mode = 0;
  int rx_phase = 0;
  logic [7:0] want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_thresholds.size() == 0) begin
        errors++;
        if (mismatches + errors <= 10) $display("unexpected threshold %0d", out_tdata);
      end else begin
        want = pending_thresholds.pop_front();
        if (out_tdata !== want) begin
          mismatches++;
          if (mismatches + errors <= 10)
            $display("threshold mismatch: expected %0d, actual %0d", want, out_tdata);
        end
      end
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    rx_phase++;
    if (rx_phase % 64 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= (rx_phase % 3 == 0);
      endcase
    end
  end

  task automatic write_reg(input oht_pkg::cfg_idx_t idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[oht_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      oht_pkg::CFG_FRAME_WIDTH: cur_width = value[8:0];
      oht_pkg::CFG_FIRST_ROW:   cur_first_row = value[7:0];
      oht_pkg::CFG_MARGIN:      cur_margin = value[7:0];
      oht_pkg::CFG_MIN_THR:     cur_min_thr = value[7:0];
      oht_pkg::CFG_FALLBACK:    cur_fallback = value[7:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [7:0] pix, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(pix, last);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_thresholds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned fr, input int unsigned mg,
                            input int unsigned mn, input int unsigned fb);
    wait_drained();
    write_reg(oht_pkg::CFG_FRAME_WIDTH, w);
    write_reg(oht_pkg::CFG_FIRST_ROW, fr);
    write_reg(oht_pkg::CFG_MARGIN, mg);
    write_reg(oht_pkg::CFG_MIN_THR, mn);
    write_reg(oht_pkg::CFG_FALLBACK, fb);
    cfg_we <= 1'b0;
  endtask

  // Content styles: 0 full range, 1 narrow band, 2 two clusters, 3 extremes only.
  task automatic send_frame(input int n_pix, input int style);
    logic [7:0] base, pix;
    base = 8'($urandom);
    for (int i = 0; i < n_pix; i++) begin
      case (style)
        0: pix = 8'($urandom);
        1: pix = base + 8'($urandom_range(0, 3));
        2: pix = $urandom_range(0, 1) ? 8'($urandom_range(10, 40)) : 8'($urandom_range(150, 220));
        default: pix = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      endcase
      send_pixel(pix, i == n_pix - 1);
    end
    frames_sent++;
  endtask

  task automatic send_levels(input logic [7:0] lv_a, input logic [7:0] lv_b, input int n_pix);
    for (int i = 0; i < n_pix; i++) send_pixel(i % 2 ? lv_b : lv_a, i == n_pix - 1);
    frames_sent++;
  endtask

  task automatic test_empty_region_defaults();
    send_pixel(8'd77, 1'b1);
    frames_sent++;
  endtask

  task automatic test_single_and_adjacent_levels();
    set_config(4, 0, 0, 200, 9);
    send_levels(8'd3, 8'd3, 4);
    send_levels(8'd100, 8'd101, 4);
    send_levels(8'd0, 8'd255, 4);
  endtask

  task automatic test_fallback_and_extremes();
    set_config(4, 0, 0, 255, 0);
    send_frame(8, 2);
    set_config(4, 0, 0, 0, 255);
    send_frame(8, 3);
    send_frame(8, 0);
  endtask

  task automatic test_width_limits();
    set_config(0, 1, 0, 0, 0);
    send_frame(4, 0);
    set_config(511, 0, 128, 0, 0);
    send_frame(3, 0);
    set_config(256, 0, 0, 10, 200);
    send_frame(5, 0);
  endtask

  task automatic test_margin_too_wide();
    set_config(6, 0, 3, 0, 0);
    send_frame(6, 0);
    set_config(8, 0, 255, 0, 0);
    send_frame(5, 0);
  endtask

  task automatic test_row_saturation();
    set_config(1, 255, 0, 0, 77);
    send_frame(270, 0);
  endtask

  task automatic test_output_backpressure();
    set_config(8, 1, 1, 20, 30);
    hold_request = 4000;
    repeat (3) send_frame($urandom_range(10, 30), $urandom_range(0, 3));
    wait_drained();
  endtask

  task automatic test_random_frames();
    int w, rows;
    while (pixels_sent < 800) begin
      w = $urandom_range(1, 16);
      if ($urandom_range(0, 9) == 0) w = ($urandom_range(0, 1) ? 256 : 1);
      set_config(w, $urandom_range(0, 3), $urandom_range(0, 4),
                 $urandom_range(0, 9) == 0 ? 255 : $urandom_range(0, 120), $urandom);
      repeat ($urandom_range(1, 3)) begin
        rows = $urandom_range(1, 5);
        send_frame($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : rows * (w > 16 ? 2 : w),
                   $urandom_range(0, 3));
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    cur_width = oht_pkg::RST_FRAME_WIDTH;
    cur_first_row = oht_pkg::RST_FIRST_ROW;
    cur_margin = oht_pkg::RST_MARGIN;
    cur_min_thr = oht_pkg::RST_MIN_THR;
    cur_fallback = oht_pkg::RST_FALLBACK;
    clear_frame_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_region_defaults();
    test_single_and_adjacent_levels();
    test_fallback_and_extremes();
    test_width_limits();
    test_margin_too_wide();
    test_row_saturation();
    test_output_backpressure();
    test_random_frames();
    wait_drained();
    repeat (600) @(posedge clk);
    $display("Sent %0d pixels in %0d frames and checked %0d thresholds.",
             pixels_sent, frames_sent, results_seen);
    $display("Covered width, margin and row limits, single and adjacent levels, fallback " +
             "and back-pressure.");
    if (mismatches == 0 && errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d unexpected results", mismatches, errors);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout with %0d thresholds outstanding", pending_thresholds.size());
    $display("status: fail");
    $finish;
  end
endmodule
